/* rtl/core/u8dcs_pkg.sv */
// Shared types and constants for the UTF-8 codepoint set decoder.
package u8dcs_pkg;

  localparam int unsigned TABLE_SIZE = 65536;   // bitmap entries, codepoints 1 .. 65535
  localparam int unsigned CP_W       = 21;
  localparam int unsigned COUNT_W    = 17;
  localparam int unsigned WORD_W     = 32;      // bitmap bits per memory row
  localparam int unsigned OFF_W      = $clog2(WORD_W);
  localparam int unsigned IDX_W      = $clog2(TABLE_SIZE);
  localparam int unsigned ROWS       = (TABLE_SIZE + WORD_W - 1) / WORD_W;
  localparam int unsigned ROW_W      = IDX_W - OFF_W;

  localparam logic [CP_W:0]      TABLE_LIM = (CP_W + 1)'(TABLE_SIZE);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [ROW_W-1:0]   ROW_LAST  = ROW_W'(ROWS - 1);

  typedef enum logic [2:0] {
    ST_PARTIAL = 3'd0,
    ST_DONE    = 3'd1,
    ST_INVALID = 3'd2,
    ST_END     = 3'd3,
    ST_SKIPPED = 3'd4,
    ST_QUERY   = 3'd5
  } status_e;

  typedef enum logic {
    OP_FEED  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  // Lead byte prefix masks and patterns
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_PAT  = 8'hF0;

  function automatic logic in_table(logic [CP_W-1:0] cp);
    return (cp != '0) && ({1'b0, cp} < TABLE_LIM);
  endfunction

endpackage

/* rtl/core/utf8_decode_codepoint_set.sv */
// Top level: UTF-8 byte decoder with a seen-codepoint bitmap in block memory.
//
//  channel | dir | tuser          | tdata
//  s_axis  | in  | opcode         | data_byte, query_codepoint
//  m_axis  | out | status         | codepoint_out, newly_added, is_cached, distinct_count
//
// One beat per cycle sustained while the output is not stalled; each beat goes through decode and
// bitmap row read, then bitmap row update into the output register.
// The bitmap row memory (one read and one write port) carries one read-modify-write per
// cycle; a row written while the next beat reads it is forwarded.
// After reset the bitmap is cleared one row per cycle, all ROWS rows (2048 at the
// default table size), with s_axis_tready_o low.
// A stalled output holds its beat; one more input beat is taken into the read stage.
module utf8_decode_codepoint_set (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [7:0] data_byte, [28:8] query_codepoint
  input  logic [0:0]  s_axis_tuser_i,   // [0] opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [20:0] codepoint_out, [21] newly_added,
                                        // [22] is_cached, [39:23] distinct_count
  output logic [2:0]  m_axis_tuser_o    // [2:0] status
);

  localparam int unsigned CP_W    = u8dcs_pkg::CP_W;
  localparam int unsigned WORD_W  = u8dcs_pkg::WORD_W;
  localparam int unsigned OFF_W   = u8dcs_pkg::OFF_W;
  localparam int unsigned IDX_W   = u8dcs_pkg::IDX_W;
  localparam int unsigned ROW_W   = u8dcs_pkg::ROW_W;
  localparam int unsigned COUNT_W = u8dcs_pkg::COUNT_W;

  // ---------------- input fields ----------------
  logic [7:0]      in_byte;
  logic [CP_W-1:0] in_qcp;
  logic            in_query;
  assign in_byte  = s_axis_tdata_i[7:0];
  assign in_qcp   = s_axis_tdata_i[28:8];
  assign in_query = (s_axis_tuser_i[0] == u8dcs_pkg::OP_QUERY);

  // ---------------- control ----------------
  logic             clr_busy_q;
  logic [ROW_W-1:0] clr_row_q;
  logic             s1_valid_q, out_valid_q;
  logic             s1_adv, accept;

  assign s1_adv          = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !clr_busy_q && (!s1_valid_q || s1_adv);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------- decoder state ----------------
  logic [1:0]      bl_q, bl_d;
  logic [CP_W-1:0] pv_q, pv_d;
  logic            skip_q, skip_d;
  u8dcs_pkg::status_e dec_status;
  logic            dec_done;
  logic [CP_W-1:0] dec_cp;

  always_comb begin
    bl_d       = bl_q;
    pv_d       = pv_q;
    skip_d     = skip_q;
    dec_status = u8dcs_pkg::ST_PARTIAL;
    dec_done   = 1'b0;
    dec_cp     = '0;
    if (skip_q) begin
      if (in_byte == 8'd0) begin
        skip_d     = 1'b0;
        dec_status = u8dcs_pkg::ST_END;
      end else begin
        dec_status = u8dcs_pkg::ST_SKIPPED;
      end
    end else if (bl_q == 2'd0) begin
      priority if (in_byte == 8'd0) begin
        dec_status = u8dcs_pkg::ST_END;
      end else if (!in_byte[7]) begin
        dec_done = 1'b1;
        dec_cp   = CP_W'(in_byte);
      end else if ((in_byte & u8dcs_pkg::LEAD2_MASK) == u8dcs_pkg::LEAD2_PAT) begin
        pv_d = CP_W'(in_byte[4:0]);
        bl_d = 2'd1;
      end else if ((in_byte & u8dcs_pkg::LEAD3_MASK) == u8dcs_pkg::LEAD3_PAT) begin
        pv_d = CP_W'(in_byte[3:0]);
        bl_d = 2'd2;
      end else if ((in_byte & u8dcs_pkg::LEAD4_MASK) == u8dcs_pkg::LEAD4_PAT) begin
        pv_d = CP_W'(in_byte[2:0]);
        bl_d = 2'd3;
      end else begin
        dec_status = u8dcs_pkg::ST_INVALID;
        skip_d     = 1'b1;
      end
    end else begin
      if (in_byte == 8'd0) begin
        // NUL inside a sequence: drop the partial value
        dec_status = u8dcs_pkg::ST_INVALID;
        bl_d       = 2'd0;
        pv_d       = '0;
      end else begin
        pv_d = {pv_q[CP_W-7:0], in_byte[5:0]};
        bl_d = bl_q - 2'd1;
        if (bl_q == 2'd1) begin
          dec_done = 1'b1;
          dec_cp   = pv_d;
          pv_d     = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bl_q   <= 2'd0;
      pv_q   <= '0;
      skip_q <= 1'b0;
    end else if (accept && !in_query) begin
      bl_q   <= bl_d;
      pv_q   <= pv_d;
      skip_q <= skip_d;
    end
  end

  // ---------------- bitmap lookup address ----------------
  logic [CP_W-1:0]  lk_cp;
  logic             lk_ok;
  logic [ROW_W-1:0] lk_row;
  assign lk_cp  = in_query ? in_qcp : dec_cp;
  assign lk_ok  = (in_query || dec_done) && u8dcs_pkg::in_table(lk_cp);
  assign lk_row = lk_cp[IDX_W-1:OFF_W];

  // ---------------- bitmap memory ----------------
  logic [WORD_W-1:0] map_mem [u8dcs_pkg::ROWS];
  logic [WORD_W-1:0] rd_data_q;
  logic              mem_we;
  logic [ROW_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              map_we;
  logic [WORD_W-1:0] map_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_data_q <= map_mem[lk_row];
    end
  end

  // ---------------- read stage (s1) ----------------
  logic               s1_query_q, s1_done_q, s1_ok_q, s1_fwd_q;
  u8dcs_pkg::status_e s1_status_q;
  logic [CP_W-1:0]    s1_cp_q;
  logic [ROW_W-1:0]   s1_row_q;
  logic [OFF_W-1:0]   s1_off_q;
  logic [WORD_W-1:0]  s1_fwd_data_q;
  logic [COUNT_W-1:0] total_q, total_d;

  logic [WORD_W-1:0] row_data;
  logic              bit_seen, s1_added, s1_cached;

  assign row_data  = s1_fwd_q ? s1_fwd_data_q : rd_data_q;
  assign bit_seen  = row_data[s1_off_q];
  assign s1_added  = s1_done_q && s1_ok_q && !bit_seen;
  assign s1_cached = s1_query_q && s1_ok_q && bit_seen;
  assign map_we    = s1_adv && s1_added;
  assign map_wdata = row_data | (WORD_W'(1) << s1_off_q);
  assign total_d   = (s1_added && total_q != u8dcs_pkg::COUNT_MAX) ?
                     total_q + COUNT_W'(1) : total_q;

  assign mem_we    = clr_busy_q || map_we;
  assign mem_waddr = clr_busy_q ? clr_row_q : s1_row_q;
  assign mem_wdata = clr_busy_q ? '0 : map_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_row_q  <= '0;
      s1_valid_q <= 1'b0;
      total_q    <= '0;
    end else begin
      if (clr_busy_q) begin
        clr_row_q <= clr_row_q + ROW_W'(1);
        if (clr_row_q == u8dcs_pkg::ROW_LAST) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        total_q <= total_d;
      end
    end
  end

  // payload of the read stage; the row written this cycle is forwarded if reread
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_query_q    <= in_query;
      s1_done_q     <= !in_query && dec_done;
      s1_ok_q       <= lk_ok;
      s1_status_q   <= in_query ? u8dcs_pkg::ST_QUERY :
                       (dec_done ? u8dcs_pkg::ST_DONE : dec_status);
      s1_cp_q       <= in_query ? '0 : dec_cp;
      s1_row_q      <= lk_row;
      s1_off_q      <= lk_cp[OFF_W-1:0];
      s1_fwd_q      <= map_we && (s1_row_q == lk_row);
      s1_fwd_data_q <= map_wdata;
    end
  end

  // ---------------- output register ----------------
  u8dcs_pkg::status_e out_status_q;
  logic [CP_W-1:0]    out_cp_q;
  logic               out_added_q, out_cached_q;
  logic [COUNT_W-1:0] out_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_status_q <= s1_status_q;
      out_cp_q     <= s1_cp_q;
      out_added_q  <= s1_added;
      out_cached_q <= s1_cached;
      out_count_q  <= total_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {out_count_q, out_cached_q, out_added_q, out_cp_q};

`ifndef ASSERT_OFF
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s_axis_tready_o)
    else $error("input taken during bitmap clear");

  a_fwd_on_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && map_we && s1_row_q == lk_row) |=> s1_fwd_q)
    else $error("row rewritten under a read was not forwarded");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(clr_busy_q) |-> total_q >= $past(total_q))
    else $error("distinct count went down");

  a_added_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[21]) |-> m_axis_tuser_o == u8dcs_pkg::ST_DONE)
    else $error("new mark on a beat that completed no codepoint");

  a_cached_only_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[22]) |-> m_axis_tuser_o == u8dcs_pkg::ST_QUERY)
    else $error("cached flag on a non-query beat");
`endif

endmodule

/* verif/utf8_decode_codepoint_set_tb.sv */
// Self-checking stream testbench for the UTF-8 codepoint set decoder.
`timescale 1ns / 100ps

module utf8_decode_codepoint_set_tb;

  localparam int unsigned CP_W       = u8dcs_pkg::CP_W;
  localparam int unsigned COUNT_W    = u8dcs_pkg::COUNT_W;
  localparam int unsigned TABLE_SIZE = u8dcs_pkg::TABLE_SIZE;

  typedef struct packed {
    u8dcs_pkg::opcode_e op;
    logic [7:0]         octet;
    logic [CP_W-1:0]    qcp;
  } beat_in_t;

  typedef struct packed {
    u8dcs_pkg::status_e  st;
    logic [CP_W-1:0]     cp;
    logic                added;
    logic                cached;
    logic [COUNT_W-1:0]  count;
  } beat_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [0:0]  s_tuser = u8dcs_pkg::OP_FEED;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [2:0]  m_tuser;

  utf8_decode_codepoint_set uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // stimulus and expectation stores
  beat_in_t          byte_queue[$];
  beat_out_t         expected_out[$];
  logic [CP_W-1:0]   cp_pool[$];
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  int unsigned       n_queued = 0;
  int unsigned       errors = 0;

  // decoder shadow state
  bit                  seen_cp [TABLE_SIZE];
  logic [COUNT_W-1:0]  distinct = '0;
  logic [1:0]          left = '0;
  logic [CP_W-1:0]     acc = '0;
  logic                skipping = 1'b0;

  int unsigned n_feed = 0, n_query = 0, n_done = 0, n_new = 0, n_bad = 0;

  function automatic bit in_range(input logic [CP_W-1:0] c);
    return (c != '0) && (c < TABLE_SIZE);
  endfunction

  function automatic beat_out_t decode_step(input beat_in_t it);
    beat_out_t r;
    logic      done;
    r.st = u8dcs_pkg::ST_PARTIAL;
    r.cp = '0;
    r.added = 1'b0;
    r.cached = 1'b0;
    done = 1'b0;
    if (it.op == u8dcs_pkg::OP_QUERY) begin
      n_query++;
      r.st = u8dcs_pkg::ST_QUERY;
      r.cached = in_range(it.qcp) && seen_cp[it.qcp];
    end else begin
      n_feed++;
      if (skipping) begin
        if (it.octet == 8'h00) begin
          skipping = 1'b0;
          r.st = u8dcs_pkg::ST_END;
        end else begin
          r.st = u8dcs_pkg::ST_SKIPPED;
        end
      end else if (left == 2'd0) begin
        if (it.octet == 8'h00) begin
          r.st = u8dcs_pkg::ST_END;
        end else if (!it.octet[7]) begin
          acc = CP_W'(it.octet);
          done = 1'b1;
        end else if ((it.octet & u8dcs_pkg::LEAD2_MASK) == u8dcs_pkg::LEAD2_PAT) begin
          acc = CP_W'(it.octet & 8'h1F);
          left = 2'd1;
        end else if ((it.octet & u8dcs_pkg::LEAD3_MASK) == u8dcs_pkg::LEAD3_PAT) begin
          acc = CP_W'(it.octet & 8'h0F);
          left = 2'd2;
        end else if ((it.octet & u8dcs_pkg::LEAD4_MASK) == u8dcs_pkg::LEAD4_PAT) begin
          acc = CP_W'(it.octet & 8'h07);
          left = 2'd3;
        end else begin
          r.st = u8dcs_pkg::ST_INVALID;
          skipping = 1'b1;
        end
      end else if (it.octet == 8'h00) begin
        // NUL cuts the sequence short; partial value is dropped
        r.st = u8dcs_pkg::ST_INVALID;
        left = 2'd0;
        acc = '0;
      end else begin
        acc = {acc[CP_W-7:0], it.octet[5:0]};
        left = left - 2'd1;
        done = (left == 2'd0);
      end
    end
    if (done) begin
      n_done++;
      r.st = u8dcs_pkg::ST_DONE;
      r.cp = acc;
      if (in_range(acc) && !seen_cp[acc]) begin
        seen_cp[acc] = 1'b1;
        if (distinct != u8dcs_pkg::COUNT_MAX) distinct++;
        r.added = 1'b1;
        n_new++;
      end
      acc = '0;
    end
    if (r.st == u8dcs_pkg::ST_INVALID) n_bad++;
    r.count = distinct;
    return r;
  endfunction

  // driver: presents the head of byte_queue, predicts on each accepted beat
  always @(posedge clk_i) begin : drive
    if (s_tvalid && s_tready) expected_out.push_back(decode_step(byte_queue.pop_front()));
    if (s_tvalid && !s_tready) begin
      // hold the beat
    end else if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      s_tvalid <= 1'b1;
      s_tdata <= {3'b000, byte_queue[0].qcp, byte_queue[0].octet};
      s_tuser <= byte_queue[0].op;
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endtask

  // monitor: compares each result beat with the oldest expectation
  always @(posedge clk_i) begin : watch
    beat_out_t want;
    if (m_tvalid && m_tready) begin
      if (expected_out.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, status %0d cp 0x%0h",
                 $time, m_tuser, m_tdata[20:0]);
      end else begin
        want = expected_out.pop_front();
        check_field("status", want.st, m_tuser);
        check_field("codepoint_out", want.cp, m_tdata[20:0]);
        check_field("newly_added", want.added, m_tdata[21]);
        check_field("is_cached", want.cached, m_tdata[22]);
        check_field("distinct_count", want.count, m_tdata[39:23]);
      end
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic push_byte(input logic [7:0] b);
    beat_in_t it;
    it.op = u8dcs_pkg::OP_FEED;
    it.octet = b;
    it.qcp = CP_W'($urandom);
    byte_queue.push_back(it);
    n_queued++;
  endtask

  task automatic push_query(input logic [CP_W-1:0] c);
    beat_in_t it;
    it.op = u8dcs_pkg::OP_QUERY;
    it.octet = 8'($urandom);
    it.qcp = c;
    byte_queue.push_back(it);
    n_queued++;
  endtask

  function automatic int cp_len(input logic [CP_W-1:0] c);
    if (c < 21'h80) return 1;
    if (c < 21'h800) return 2;
    if (c < 21'h10000) return 3;
    return 4;
  endfunction

  // encodes c in len bytes; sloppy puts random tag bits on continuation bytes
  task automatic push_cp(input logic [CP_W-1:0] c, input int len, input bit sloppy);
    int         k;
    logic [1:0] tag;
    case (len)
      1: push_byte({1'b0, c[6:0]});
      2: push_byte({3'b110, c[10:6]});
      3: push_byte({4'b1110, c[15:12]});
      default: push_byte({5'b11110, c[20:18]});
    endcase
    for (k = len - 2; k >= 0; k--) begin
      tag = sloppy ? 2'($urandom) : 2'b10;
      push_byte({tag, c[6*k +: 6]});
    end
  endtask

  function automatic logic [CP_W-1:0] pick_query();
    int k;
    k = $urandom_range(9);
    if (k < 5 && cp_pool.size() != 0) return cp_pool[$urandom_range(cp_pool.size() - 1)];
    if (k < 7) begin
      case ($urandom_range(4))
        0: return '0;
        1: return CP_W'(1);
        2: return CP_W'(TABLE_SIZE - 1);
        3: return CP_W'(TABLE_SIZE);
        default: return '1;
      endcase
    end
    return CP_W'($urandom);
  endfunction

  task automatic noise_string();
    int         len;
    logic [7:0] lead;
    case ($urandom_range(3))
      0: begin  // bad lead byte, rest of the string is skipped
        lead = $urandom_range(1) ? 8'($urandom_range(8'h80, 8'hBF))
                                 : 8'($urandom_range(8'hF8, 8'hFF));
        push_byte(lead);
        repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(1, 255)));
      end
      1: begin  // sequence cut short by the terminator
        len = $urandom_range(2, 4);
        lead = 8'($urandom);
        case (len)
          2: lead[7:5] = 3'b110;
          3: lead[7:4] = 4'b1110;
          default: lead[7:3] = 5'b11110;
        endcase
        push_byte(lead);
        repeat ($urandom_range(0, len - 2)) push_byte(8'($urandom_range(1, 255)));
      end
      2: begin
        len = $urandom_range(1, 4);
        push_cp(CP_W'($urandom), len, 1'b1);
      end
      default: repeat ($urandom_range(1, 8)) push_byte(8'($urandom));
    endcase
    push_byte(8'h00);
  endtask

  task automatic random_string();
    int              kind;
    logic [CP_W-1:0] c;
    if ($urandom_range(99) < 18) begin
      noise_string();
    end else begin
      repeat ($urandom_range(1, 5)) begin
        kind = $urandom_range(99);
        if (kind < 12) begin
          push_query(pick_query());
        end else begin
          if (kind < 40) c = CP_W'($urandom_range(1, 127));
          else if (kind < 56) c = CP_W'($urandom_range(128, 2047));
          else if (kind < 70) c = CP_W'($urandom_range(2048, 65535));
          else if (kind < 80) c = CP_W'($urandom_range(65536, 21'h1FFFFF));
          else c = cp_pool[$urandom_range(cp_pool.size() - 1)];
          push_cp(c, cp_len(c), 1'b0);
          if (cp_pool.size() < 64) cp_pool.push_back(c);
        end
      end
      push_byte(8'h00);
    end
  endtask

  task automatic drain();
    while (byte_queue.size() != 0 || expected_out.size() != 0) @(posedge clk_i);
  endtask

  task automatic directed_strings();
    push_byte(8'h41);
    push_byte(8'h41);                    // same codepoint again: no new mark
    push_byte(8'hC3);
    push_query(CP_W'(21'h41));           // query between sequence bytes
    push_byte(8'hA9);
    push_cp('0, 2, 1'b0);                // overlong zero
    push_cp(CP_W'(21'h20AC), 3, 1'b0);
    push_cp('1, 4, 1'b0);                // largest value, outside the table
    push_byte(8'h00);
    push_byte(8'h80);                    // stray continuation as lead
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'hE2);
    push_byte(8'h00);                    // terminator inside a sequence
    push_byte(8'hF8);
    push_byte(8'h00);
    push_query('0);
    push_query('1);
    push_query(CP_W'(21'hE9));
  endtask

  initial begin : stimulus
    cp_pool.push_back(CP_W'(TABLE_SIZE - 1));
    cp_pool.push_back(CP_W'(TABLE_SIZE));
    cp_pool.push_back(CP_W'(21'h41));
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 18;
    recv_idle_pct = 76;
    directed_strings();
    while (n_queued < 160) random_string();
    drain();

    send_idle_pct = 76;
    recv_idle_pct = 18;
    while (n_queued < 305) random_string();
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (n_queued < 450) random_string();
    drain();
    repeat (10) @(posedge clk_i);

    if (expected_out.size() != 0) begin
      errors += expected_out.size();
      $display("%0t: %0d expected results never arrived", $time, expected_out.size());
    end
    $display("Covered %0d string bytes and %0d queries: %0d codepoints decoded,",
             n_feed, n_query, n_done);
    $display("  %0d first-time marks (count %0d), %0d invalid or cut sequences.",
             n_new, distinct, n_bad);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Timeout with %0d beats pending, %0d results outstanding",
             byte_queue.size(), expected_out.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
